FILE: hw/rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the pressure panel press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

    localparam int NUM_PANELS          = 4;
    localparam int NUM_SENSORS         = 4;
    localparam int DATA_W              = 16;
    localparam int PANEL_W             = $clog2(NUM_PANELS);
    localparam int CALIBRATION_REPORTS = 10;
    // holds 0 .. CALIBRATION_REPORTS+1
    localparam int CNT_W               = $clog2(CALIBRATION_REPORTS + 2);
    localparam int PADDR_W             = 5;
    localparam int PDATA_W             = 32;
    localparam int REG_IDX_W           = 3;

    // Panel that closes a report
    localparam logic [PANEL_W-1:0] PANEL_LAST = PANEL_W'(NUM_PANELS - 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD_LEFT,
        REG_THRESHOLD_DOWN,
        REG_THRESHOLD_UP,
        REG_THRESHOLD_RIGHT,
        REG_COOLDOWN_LEFT,
        REG_COOLDOWN_DOWN,
        REG_COOLDOWN_UP,
        REG_COOLDOWN_RIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_PANELS-1:0][DATA_W-1:0] threshold;
        logic [NUM_PANELS-1:0][DATA_W-1:0] cooldown;
    } cfg_t;

    typedef struct packed {
        logic [PANEL_W-1:0]                 panel;
        logic [NUM_SENSORS-1:0][DATA_W-1:0] sensor;
    } item_t;

    typedef struct packed {
        logic [PANEL_W-1:0] panel;
        logic [DATA_W-1:0]  sum;
        logic               pressed;
        logic               changed;
        logic               calibrated;
    } result_t;

    typedef struct packed {
        logic calibrated;
        logic capturing;
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pressure_panel_press_detector_core.sv
// ----------------------------------------------------------------------------
// pressure_panel_press_detector_core
// Per-panel press detector with baseline calibration and release hysteresis.
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  s_       | s_valid/s_ready   | panel_index, sensor_0..sensor_3
//  m_       | m_valid/m_ready   | panel_out, panel_sum, pressed, changed,
//           |                   | calibrated
//  apb      | psel/penable      | paddr (4*index), pwdata/prdata, 8 x 16 bit
//
//  One item per cycle sustained while m_ready is high. An item passes the
//  input register, then the sum/compare logic feeding the result register.
//  Panel state (baselines, pressed flags, report count) updates as an item
//  moves into the result register, so consecutive items see each other.
//  Reset (aresetn low, synchronous) clears config and all panel state.
//  Stall on m_ready holds the result; the input register still takes one
//  item, after which s_ready follows m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_panel_press_detector_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [ppd_pkg::PANEL_W-1:0] s_panel_index,
    input  wire logic [ppd_pkg::DATA_W-1:0]  s_sensor_0,
    input  wire logic [ppd_pkg::DATA_W-1:0]  s_sensor_1,
    input  wire logic [ppd_pkg::DATA_W-1:0]  s_sensor_2,
    input  wire logic [ppd_pkg::DATA_W-1:0]  s_sensor_3,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [ppd_pkg::PANEL_W-1:0] m_panel_out,
    output logic      [ppd_pkg::DATA_W-1:0]  m_panel_sum,
    output logic                             m_pressed,
    output logic                             m_changed,
    output logic                             m_calibrated,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ppd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ppd_pkg::PDATA_W-1:0] pwdata,
    output logic      [ppd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import ppd_pkg::*;

    cfg_t    cfg;
    status_t status;
    result_t judged;

    // input stage
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    item_t   in_item_next;

    // result stage
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    logic    out_free;
    logic    advance;
    logic    s_take;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    ppd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppd_judge u_judge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (judged),
        .status  (status)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_take) begin
            in_valid_next       = 1'b1;
            in_item_next.panel  = s_panel_index;
            in_item_next.sensor = {s_sensor_3, s_sensor_2, s_sensor_1, s_sensor_0};
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_next       = judged;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_reg     <= out_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_panel_out  = out_reg.panel;
    assign m_panel_sum  = out_reg.sum;
    assign m_pressed    = out_reg.pressed;
    assign m_changed    = out_reg.changed;
    assign m_calibrated = out_reg.calibrated;

    // a held input item is never dropped before it moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost while stalled");

    // calibration is sticky
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.calibrated |=> status.calibrated)
        else $error("calibrated flag fell");

    // a press event needs a captured baseline
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_changed) |-> m_calibrated)
        else $error("button event before calibration");

    // capture window only opens while uncalibrated
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.capturing |-> !status.calibrated)
        else $error("capturing after calibration");

endmodule

`default_nettype wire

FILE: hw/rtl/ppd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppd_cfg_regs
// APB-style register file: per-panel thresholds and cooldowns.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ppd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ppd_pkg::PDATA_W-1:0] pwdata,
    output logic      [ppd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output ppd_pkg::cfg_t                    cfg
);
    import ppd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;
    logic [DATA_W-1:0] rd_val;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_THRESHOLD_LEFT:  cfg_next.threshold[0] = pwdata[DATA_W-1:0];
                REG_THRESHOLD_DOWN:  cfg_next.threshold[1] = pwdata[DATA_W-1:0];
                REG_THRESHOLD_UP:    cfg_next.threshold[2] = pwdata[DATA_W-1:0];
                REG_THRESHOLD_RIGHT: cfg_next.threshold[3] = pwdata[DATA_W-1:0];
                REG_COOLDOWN_LEFT:   cfg_next.cooldown[0]  = pwdata[DATA_W-1:0];
                REG_COOLDOWN_DOWN:   cfg_next.cooldown[1]  = pwdata[DATA_W-1:0];
                REG_COOLDOWN_UP:     cfg_next.cooldown[2]  = pwdata[DATA_W-1:0];
                REG_COOLDOWN_RIGHT:  cfg_next.cooldown[3]  = pwdata[DATA_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD_LEFT:  rd_val = cfg_reg.threshold[0];
            REG_THRESHOLD_DOWN:  rd_val = cfg_reg.threshold[1];
            REG_THRESHOLD_UP:    rd_val = cfg_reg.threshold[2];
            REG_THRESHOLD_RIGHT: rd_val = cfg_reg.threshold[3];
            REG_COOLDOWN_LEFT:   rd_val = cfg_reg.cooldown[0];
            REG_COOLDOWN_DOWN:   rd_val = cfg_reg.cooldown[1];
            REG_COOLDOWN_UP:     rd_val = cfg_reg.cooldown[2];
            REG_COOLDOWN_RIGHT:  rd_val = cfg_reg.cooldown[3];
            default:             rd_val = '0;
        endcase
    end

    assign prdata = PDATA_W'(rd_val);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ppd_judge.sv
// ----------------------------------------------------------------------------
// ppd_judge
// Sensor sum, baseline capture, press/release decision and panel state.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_judge (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,  // item leaves the input stage
    input  ppd_pkg::item_t        item,
    input  ppd_pkg::cfg_t         cfg,
    output ppd_pkg::result_t      result,
    output ppd_pkg::status_t      status
);
    import ppd_pkg::*;

    logic [NUM_PANELS-1:0][DATA_W-1:0] baseline_reg;
    logic [NUM_PANELS-1:0][DATA_W-1:0] baseline_next;
    logic [NUM_PANELS-1:0]             pressed_reg;
    logic [NUM_PANELS-1:0]             pressed_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              cal_reg;
    logic                              cal_next;

    logic [DATA_W-1:0]   sum;
    logic                capturing;
    logic [DATA_W-1:0]   base;
    logic [DATA_W-1:0]   thr;
    logic [DATA_W-1:0]   cool;
    logic [DATA_W:0]     level;     // no wrap
    logic signed [DATA_W+1:0] rel;  // may go negative
    logic                was_pressed;
    logic                now;

    assign sum = item.sensor[0] + item.sensor[1] + item.sensor[2] + item.sensor[3];

    assign capturing   = !cal_reg && (count_reg > CNT_W'(CALIBRATION_REPORTS));
    assign base        = capturing ? sum : baseline_reg[item.panel];
    assign thr         = cfg.threshold[item.panel];
    assign cool        = cfg.cooldown[item.panel];
    assign level       = {1'b0, base} + {1'b0, thr};
    assign rel         = $signed({1'b0, level}) - $signed({2'b00, cool});
    assign was_pressed = pressed_reg[item.panel];

    always_comb begin
        now = was_pressed;
        if (base != '0 && thr != '0) begin
            priority if (!was_pressed && ({1'b0, sum} > level)) begin
                now = 1'b1;
            end else if (was_pressed && ($signed({2'b00, sum}) < rel)) begin
                now = 1'b0;
            end
        end
    end

    always_comb begin
        baseline_next = baseline_reg;
        pressed_next  = pressed_reg;
        count_next    = count_reg;
        cal_next      = cal_reg;
        if (advance) begin
            if (capturing) begin
                baseline_next[item.panel] = sum;
            end
            pressed_next[item.panel] = now;
            if (item.panel == PANEL_LAST) begin
                priority if (capturing) begin
                    cal_next = 1'b1;
                end else if (!cal_reg && count_reg <= CNT_W'(CALIBRATION_REPORTS)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign result.panel      = item.panel;
    assign result.sum        = sum;
    assign result.pressed    = now;
    assign result.changed    = now ^ was_pressed;
    assign result.calibrated = cal_reg || capturing;

    assign status.calibrated = cal_reg;
    assign status.capturing  = capturing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            pressed_reg  <= '0;
            count_reg    <= '0;
            cal_reg      <= 1'b0;
        end else begin
            baseline_reg <= baseline_next;
            pressed_reg  <= pressed_next;
            count_reg    <= count_next;
            cal_reg      <= cal_next;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure panel press detector core: streams
// sensor items through the valid/ready channels, programs thresholds and
// cooldowns over APB, and checks every result against a cycle-free model.
// ----------------------------------------------------------------------------

module tb;

    import ppd_pkg::*;

    // Generous cap on the run length.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // ------------------------------------------------------------------------
    // Expected-result tracker: mirrors the panel state and config, predicts
    // one result per accepted item and matches results in order.
    // ------------------------------------------------------------------------
    class press_tracker;
        logic [DATA_W-1:0] threshold [NUM_PANELS];
        logic [DATA_W-1:0] cooldown  [NUM_PANELS];
        logic [DATA_W-1:0] baseline  [NUM_PANELS];
        bit                pressed   [NUM_PANELS];
        int unsigned       reports;
        bit                calibrated;
        result_t           due_results [$];
        int                errors;
        int                matched;
        int                presses;
        int                releases;

        function new();
            for (int i = 0; i < NUM_PANELS; i++) begin
                threshold[i] = '0;
                cooldown[i]  = '0;
                baseline[i]  = '0;
                pressed[i]   = 1'b0;
            end
            reports    = 0;
            calibrated = 1'b0;
            errors     = 0;
            matched    = 0;
            presses    = 0;
            releases   = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            if (int'(idx) < int'(REG_COOLDOWN_LEFT)) begin
                threshold[int'(idx)] = value;
            end else begin
                cooldown[int'(idx) - int'(REG_COOLDOWN_LEFT)] = value;
            end
        endfunction

        function void predict_press(item_t it);
            int unsigned       p;
            logic [DATA_W-1:0] sum;
            bit                capture;
            bit                was;
            int                level;
            int                rel;
            result_t           r;
            p   = 32'(it.panel);
            // 16-bit context: wraps like the hardware adder tree
            sum = it.sensor[0] + it.sensor[1] + it.sensor[2] + it.sensor[3];
            capture = !calibrated && (reports > CALIBRATION_REPORTS);
            was     = pressed[p];
            if (capture) begin
                baseline[p] = sum;
            end
            // zero baseline or zero threshold: panel not judged
            if (baseline[p] != '0 && threshold[p] != '0) begin
                // full-width level, signed release point
                level = int'(baseline[p]) + int'(threshold[p]);
                rel   = level - int'(cooldown[p]);
                if (!was && int'(sum) > level) begin
                    pressed[p] = 1'b1;
                end else if (was && int'(sum) < rel) begin
                    pressed[p] = 1'b0;
                end
            end
            if (it.panel == PANEL_LAST) begin
                if (capture) begin
                    calibrated = 1'b1;
                end else if (!calibrated && reports <= CALIBRATION_REPORTS) begin
                    reports++;
                end
            end
            r.panel      = it.panel;
            r.sum        = sum;
            r.pressed    = pressed[p];
            r.changed    = pressed[p] != was;
            r.calibrated = calibrated || capture;
            due_results = {due_results, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, panel %0d sum %0d",
                         $time, got.panel, got.sum);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("panel_out", 32'(want.panel), 32'(got.panel));
            compare_field("panel_sum", 32'(want.sum), 32'(got.sum));
            compare_field("pressed", 32'(want.pressed), 32'(got.pressed));
            compare_field("changed", 32'(want.changed), 32'(got.changed));
            compare_field("calibrated", 32'(want.calibrated), 32'(got.calibrated));
            if (want.changed) begin
                if (want.pressed) presses++;
                else releases++;
            end
            matched++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every bench-driven signal known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [PANEL_W-1:0]   s_panel_index = '0;
    logic [DATA_W-1:0]    s_sensor_0    = '0;
    logic [DATA_W-1:0]    s_sensor_1    = '0;
    logic [DATA_W-1:0]    s_sensor_2    = '0;
    logic [DATA_W-1:0]    s_sensor_3    = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [PANEL_W-1:0]   m_panel_out;
    logic [DATA_W-1:0]    m_panel_sum;
    logic                 m_pressed;
    logic                 m_changed;
    logic                 m_calibrated;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    press_tracker         tracker       = new();
    idle_mode_t           idle_mode     = IDLE_NONE;
    int                   hold_request  = 0;   // handed to the receiver process
    int                   reg_errors    = 0;
    int                   items_sent    = 0;
    int                   cycle_count   = 0;
    logic [DATA_W-1:0]    thr_set  [NUM_PANELS];
    logic [DATA_W-1:0]    cool_set [NUM_PANELS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pressure_panel_press_detector_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_panel_index (s_panel_index),
        .s_sensor_0    (s_sensor_0),
        .s_sensor_1    (s_sensor_1),
        .s_sensor_2    (s_sensor_2),
        .s_sensor_3    (s_sensor_3),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_panel_out   (m_panel_out),
        .m_panel_sum   (m_panel_sum),
        .m_pressed     (m_pressed),
        .m_changed     (m_changed),
        .m_calibrated  (m_calibrated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic item_t pack_item(int unsigned p, logic [DATA_W-1:0] a,
                                        logic [DATA_W-1:0] b, logic [DATA_W-1:0] c,
                                        logic [DATA_W-1:0] d);
        item_t it;
        it.panel     = PANEL_W'(p);
        it.sensor[0] = a;
        it.sensor[1] = b;
        it.sensor[2] = c;
        it.sensor[3] = d;
        return it;
    endfunction

    // Random readings that add up (mod 2^16) to the wanted panel sum
    function automatic item_t make_item(int unsigned p, logic [DATA_W-1:0] target);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        a = DATA_W'($urandom);
        b = DATA_W'($urandom);
        c = DATA_W'($urandom);
        return pack_item(p, a, b, c, target - a - b - c);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: drives at the falling edge, item taken at the rising edge with
    // valid and ready high. Valid stays up between back-to-back items.
    // ------------------------------------------------------------------------
    task automatic send_item(input item_t it);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_panel_index = it.panel;
        s_sensor_0    = it.sensor[0];
        s_sensor_1    = it.sensor[1];
        s_sensor_2    = it.sensor[2];
        s_sensor_3    = it.sensor[3];
        do @(posedge aclk); while (!s_ready);
        tracker.predict_press(it);
        items_sent++;
    endtask

    // Drop valid and let every outstanding result come out, plus slack for
    // the two-stage pipe, before touching the registers.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup cycle, then access; write lands at the access edge
    // ------------------------------------------------------------------------
    task automatic apb_xfer(input bit wr, input reg_idx_t idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = PADDR_W'(4 * int'(idx));
        pwdata  = PDATA_W'(wdata);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write, mirror into the tracker, read back
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        tracker.set_reg(idx, value);
        apb_xfer(1'b0, idx, '0, rd);
        if (rd[DATA_W-1:0] !== value) begin
            $display("%0t: readback of %s, expected %0d got %0d",
                     $time, idx.name(), value, rd[DATA_W-1:0]);
            reg_errors++;
        end
    endtask

    task automatic program_regs();
        for (int i = 0; i < NUM_PANELS; i++) begin
            write_reg(reg_idx_t'(int'(REG_THRESHOLD_LEFT) + i), thr_set[i]);
            write_reg(reg_idx_t'(int'(REG_COOLDOWN_LEFT) + i), cool_set[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready decided at the falling edge. A hold-off request is
    // counted down here, so the sender keeps pushing and the pipe backs up.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int stall_pct;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 47 :
                        (idle_mode == IDLE_BOTH)     ? 10 : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    // Result monitor: sample at the rising edge
    always @(posedge aclk) begin : monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.panel      = m_panel_out;
            got.sum        = m_panel_sum;
            got.pressed    = m_pressed;
            got.changed    = m_changed;
            got.calibrated = m_calibrated;
            tracker.match_result(got);
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("pressure_panel_press_detector_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int phase;
        int n;
        int unsigned p;
        int level;
        int rel;
        int target;
        int total_errors;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Nonzero margins from the start; baselines are still zero so no
        // panel is judged until calibration.
        for (int i = 0; i < NUM_PANELS; i++) begin
            thr_set[i]  = 16'd500;
            cool_set[i] = 16'd250;
        end
        program_regs();

        // ---- directed: uncalibrated, field extremes, out-of-order reports
        idle_mode = IDLE_NONE;
        send_item(pack_item(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(pack_item(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(pack_item(2, 16'h8000, 16'h8000, 16'h0000, 16'h0000)); // wraps to 0
        send_item(make_item(3, DATA_W'($urandom)));
        send_item(pack_item(3, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        send_item(make_item(2, DATA_W'($urandom)));
        send_item(make_item(0, DATA_W'($urandom)));
        send_item(make_item(3, DATA_W'($urandom)));
        // reports four through eleven: panel 3 alone closes each
        repeat (8) send_item(make_item(3, DATA_W'($urandom)));

        // ---- capture report: a zero sum first, then overwritten baselines;
        // panel 1 sits high so a large margin cannot be reached.
        send_item(make_item(0, 16'd0));
        send_item(make_item(0, 16'd1000));
        send_item(make_item(1, 16'd65000));
        send_item(make_item(2, DATA_W'($urandom_range(1, 65535))));
        send_item(make_item(3, 16'd30000));

        // ---- panel 0 edges: level 1500, release point 1250
        send_item(make_item(0, 16'd1500));   // equal: no press
        send_item(make_item(0, 16'd1501));   // press
        send_item(make_item(0, 16'd1250));   // equal: stays pressed
        send_item(make_item(0, 16'd1249));   // release

        // ---- random phases, each with its own settings and idle pattern
        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            for (int i = 0; i < NUM_PANELS; i++) begin
                case (phase)
                    0: begin   // typical: cooldown half the margin
                        thr_set[i]  = DATA_W'($urandom_range(1, 4000));
                        cool_set[i] = thr_set[i] >> 1;
                    end
                    1: begin   // tightest margin, no hysteresis
                        thr_set[i]  = 16'd1;
                        cool_set[i] = 16'd0;
                    end
                    2: begin   // both at max: level past 16 bits
                        thr_set[i]  = 16'hFFFF;
                        cool_set[i] = 16'hFFFF;
                    end
                    4: begin   // huge cooldown: release point may go negative
                        thr_set[i]  = DATA_W'($urandom_range(1, 3000));
                        cool_set[i] = 16'hFFFF;
                    end
                    6: begin
                        thr_set[i]  = DATA_W'($urandom_range(1, 2000));
                        cool_set[i] = thr_set[i] >> 1;
                    end
                    default: begin
                        thr_set[i]  = DATA_W'($urandom);
                        cool_set[i] = DATA_W'($urandom);
                    end
                endcase
            end
            // one panel switched off by a zero margin
            if (phase == 3) thr_set[$urandom_range(0, NUM_PANELS - 1)] = '0;
            program_regs();

            idle_mode = (phase == PHASES - 1) ? IDLE_NONE : idle_mode_t'(phase % 4);
            if (phase == PHASES - 1) begin
                // long receiver hold-off while the sender keeps offering
                @(posedge aclk);
                hold_request = HOLD_CYCLES;
            end

            for (n = 0; n < PHASE_ITEMS; n++) begin
                p     = $urandom_range(0, NUM_PANELS - 1);
                level = int'(tracker.baseline[p]) + int'(tracker.threshold[p]);
                rel   = level - int'(tracker.cooldown[p]);
                // aim mostly at the press and release boundaries
                case ($urandom_range(0, 9))
                    0:       target = $urandom;
                    1, 2:    target = level - 1 + $urandom_range(0, 3);
                    3, 4:    target = rel - 2 + $urandom_range(0, 3);
                    5:       target = level + $urandom_range(0, 2000);
                    6:       target = rel - $urandom_range(0, 2000);
                    7:       target = $urandom_range(0, 1) ? 0 : 65535;
                    default: target = int'(tracker.baseline[p]) + $urandom_range(0, 200) - 100;
                endcase
                send_item(make_item(p, target[DATA_W-1:0]));
            end
        end

        drain_pipeline();
        repeat (8) @(posedge aclk);

        total_errors = tracker.errors + reg_errors;
        if (tracker.due_results.size() != 0) begin
            $display("%0d expected results never arrived", tracker.due_results.size());
            total_errors += tracker.due_results.size();
        end

        $display("covered: %0d items, %0d results matched, %0d presses, %0d releases",
                 items_sent, tracker.matched, tracker.presses, tracker.releases);
        $display("covered: calibration after %0d reports, %0d register settings, long hold-off",
                 CALIBRATION_REPORTS + 1, PHASES + 1);
        if (total_errors == 0) begin
            $display("pressure_panel_press_detector_core regression: pass");
        end else begin
            $display("pressure_panel_press_detector_core regression: fail");
        end
        $finish;
    end

endmodule
